FILE: hdl/kprt_pkg.sv
`timescale 1ns / 1ps

package kprt_pkg;

  localparam int SCAN_W = 8;
  localparam int CODE_W = 10;
  localparam int IDX_W = 5;
  localparam int MAX_REPORT_KEYS = 2;

  localparam int REPORT_KEYS_DEF = 2;
  localparam int HELD_SLOTS_DEF = 2;
  localparam int KEYMAP_SIZE_DEF = 17;

  localparam logic [CODE_W-1:0] UNKNOWN_CODE = 10'd240;

  typedef enum logic {
    OP_REPORT    = 1'b0,
    OP_MAP_WRITE = 1'b1
  } op_t;

  typedef logic [SCAN_W-1:0] scan_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic                       empty;
    logic [MAX_REPORT_KEYS-1:0] match;
  } lane_stat_t;

endpackage

FILE: hdl/kprt_ifs.sv
`timescale 1ns / 1ps

interface kprt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [kprt_pkg::SCAN_W-1:0]  key_0;
  logic [kprt_pkg::SCAN_W-1:0]  key_1;
  logic [kprt_pkg::IDX_W-1:0]   map_index;
  logic [kprt_pkg::CODE_W-1:0]  map_code;

  modport source (output valid, operation, key_0, key_1, map_index, map_code,
                  input ready);
  modport sink (input valid, operation, key_0, key_1, map_index, map_code,
                output ready);
endinterface

interface kprt_out_if;
  logic                         valid;
  logic                         ready;
  logic [kprt_pkg::SCAN_W-1:0]  scan_code;
  logic                         is_press;
  logic [kprt_pkg::CODE_W-1:0]  mapped_code;
  logic                         code_valid;
  logic                         last;

  modport source (output valid, scan_code, is_press, mapped_code, code_valid, last,
                  input ready);
  modport sink (input valid, scan_code, is_press, mapped_code, code_valid, last,
                output ready);
endinterface

FILE: hdl/keypad_press_release_tracker_unit.sv
`timescale 1ns / 1ps
// Each report's events wait in the event buffer, then pass through the lookup stage to the
// output register. Throughput: one event per cycle while the output is not stalled; a report
// holds the input until its last event enters the lookup stage, set by the single keymap read port.
// A keymap write waits until the event buffer and lookup stage are empty.
// Reset (synchronous, active low) empties all slots and the pipeline; every keymap entry reads unknown.

module keypad_press_release_tracker_unit #(
  parameter int REPORT_KEYS = kprt_pkg::REPORT_KEYS_DEF,
  parameter int HELD_SLOTS  = kprt_pkg::HELD_SLOTS_DEF,
  parameter int KEYMAP_SIZE = kprt_pkg::KEYMAP_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kprt_in_if.sink    in_req,
  kprt_out_if.source out_req
);

  import kprt_pkg::*;

  localparam int EV_N = REPORT_KEYS + HELD_SLOTS;
  localparam int EW   = (EV_N > 1) ? $clog2(EV_N) : 1;
  localparam int AW   = (KEYMAP_SIZE > 1) ? $clog2(KEYMAP_SIZE) : 1;

  logic [HELD_SLOTS-1:0][SCAN_W-1:0]  slots_r, slots_nxt, slots_upd;
  logic [REPORT_KEYS-1:0][SCAN_W-1:0] rep_keys;
  lane_stat_t [HELD_SLOTS-1:0]        lane_stat;
  logic [EV_N-1:0]                    ev_mask;
  logic [EV_N-1:0][SCAN_W-1:0]        ev_scan;

  logic                               a_valid_r, a_valid_nxt;
  logic [EV_N-1:0]                    a_mask_r, a_mask_nxt;
  logic [EV_N-1:0][SCAN_W-1:0]        a_scan_r, a_scan_nxt;
  logic [EW-1:0]                      a_sel;
  logic [EV_N-1:0]                    a_onehot;
  logic                               a_last;
  scan_t                              a_sel_scan;

  logic                               b_valid_r, b_valid_nxt;
  scan_t                              b_scan_r, b_scan_nxt;
  logic                               b_press_r, b_press_nxt;
  logic                               b_last_r, b_last_nxt;
  logic                               b_inrange_r, b_inrange_nxt;

  logic                               c_valid_r, c_valid_nxt;
  scan_t                              c_scan_r, c_scan_nxt;
  logic                               c_press_r, c_press_nxt;
  code_t                              c_code_r, c_code_nxt;
  logic                               c_cvalid_r, c_cvalid_nxt;
  logic                               c_last_r, c_last_nxt;

  logic [KEYMAP_SIZE-1:0]             map_vld_r, map_vld_nxt;
  logic                               ent_vld_r;
  code_t                              map_rd_data;
  scan_t                              rd_scan;
  logic [SCAN_W:0]                    rd_scan_w;
  logic [AW-1:0]                      raddr;
  logic [SCAN_W:0]                    wr_idx_w;
  logic [AW-1:0]                      waddr;
  logic                               wr_in_range;
  logic                               map_we;

  logic is_write, in_fire, rep_fire, wr_fire;
  logic c_load, b_free, a_drain, a_done, a_free;

  always_comb begin
    for (int i = 0; i < REPORT_KEYS; i++) begin
      rep_keys[i] = (i == 0) ? in_req.key_0 : in_req.key_1;
    end
  end

  for (genvar j = 0; j < HELD_SLOTS; j++) begin : g_lane
    kprt_lane #(
      .REPORT_KEYS(REPORT_KEYS)
    ) u_lane (
      .slot(slots_r[j]),
      .keys(rep_keys),
      .stat(lane_stat[j])
    );
  end

  kprt_merge #(
    .REPORT_KEYS(REPORT_KEYS),
    .HELD_SLOTS (HELD_SLOTS)
  ) u_merge (
    .keys     (rep_keys),
    .slots    (slots_r),
    .stats    (lane_stat),
    .slots_upd(slots_upd),
    .ev_mask  (ev_mask),
    .ev_scan  (ev_scan)
  );

  // Lowest pending event of the buffered report goes first.
  always_comb begin
    a_sel = '0;
    for (int e = EV_N - 1; e >= 0; e--) begin
      if (a_mask_r[e]) begin
        a_sel = EW'(e);
      end
    end
    a_onehot = '0;
    a_onehot[a_sel] = a_mask_r[a_sel];
    a_last = ((a_mask_r & ~a_onehot) == '0);
    a_sel_scan = a_scan_r[a_sel];
  end

  assign c_load  = b_valid_r && (!c_valid_r || out_req.ready);
  assign b_free  = !b_valid_r || c_load;
  assign a_drain = a_valid_r && b_free;
  assign a_done  = a_drain && a_last;
  assign a_free  = !a_valid_r || a_done;

  assign is_write     = (op_t'(in_req.operation) == OP_MAP_WRITE);
  assign in_req.ready = is_write ? (!a_valid_r && !b_valid_r) : a_free;
  assign in_fire      = in_req.valid && in_req.ready;
  assign rep_fire     = in_fire && !is_write;
  assign wr_fire      = in_fire && is_write;

  assign wr_idx_w    = (SCAN_W + 1)'(in_req.map_index);
  assign waddr       = wr_idx_w[AW-1:0];
  assign wr_in_range = (32'(in_req.map_index) < KEYMAP_SIZE);
  assign map_we      = wr_fire && wr_in_range;

  // The read address follows the event entering the lookup stage, or is held
  // on the stalled one so that its read data stays current.
  assign rd_scan   = a_drain ? a_sel_scan : b_scan_r;
  assign rd_scan_w = (SCAN_W + 1)'(rd_scan);
  assign raddr     = (32'(rd_scan) < KEYMAP_SIZE) ? rd_scan_w[AW-1:0] : '0;

  kprt_ram #(
    .WIDTH(CODE_W),
    .DEPTH(KEYMAP_SIZE)
  ) u_keymap (
    .clk      (clk),
    .we       (map_we),
    .waddr    (waddr),
    .wdata    (in_req.map_code),
    .raddr    (raddr),
    .rd_data_r(map_rd_data)
  );

  always_comb begin
    slots_nxt   = slots_r;
    map_vld_nxt = map_vld_r;
    if (rep_fire) begin
      slots_nxt = slots_upd;
    end
    if (map_we) begin
      map_vld_nxt[waddr] = 1'b1;
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_mask_nxt  = a_mask_r;
    a_scan_nxt  = a_scan_r;
    if (a_drain) begin
      a_mask_nxt = a_mask_r & ~a_onehot;
    end
    if (a_done) begin
      a_valid_nxt = 1'b0;
    end
    if (rep_fire) begin
      a_valid_nxt = |ev_mask;
      a_mask_nxt  = ev_mask;
      a_scan_nxt  = ev_scan;
    end
  end

  always_comb begin
    b_valid_nxt   = b_valid_r;
    b_scan_nxt    = b_scan_r;
    b_press_nxt   = b_press_r;
    b_last_nxt    = b_last_r;
    b_inrange_nxt = b_inrange_r;
    if (b_free) begin
      b_valid_nxt   = a_drain;
      b_scan_nxt    = a_sel_scan;
      b_press_nxt   = (32'(a_sel) < REPORT_KEYS);
      b_last_nxt    = a_last;
      b_inrange_nxt = (32'(a_sel_scan) < KEYMAP_SIZE);
    end
  end

  always_comb begin
    c_valid_nxt  = c_valid_r;
    c_scan_nxt   = c_scan_r;
    c_press_nxt  = c_press_r;
    c_code_nxt   = c_code_r;
    c_cvalid_nxt = c_cvalid_r;
    c_last_nxt   = c_last_r;
    if (c_load) begin
      c_valid_nxt  = 1'b1;
      c_scan_nxt   = b_scan_r;
      c_press_nxt  = b_press_r;
      c_last_nxt   = b_last_r;
      c_code_nxt   = (b_inrange_r && ent_vld_r) ? map_rd_data : UNKNOWN_CODE;
      c_cvalid_nxt = b_inrange_r && ent_vld_r && (map_rd_data != UNKNOWN_CODE);
    end else if (out_req.ready) begin
      c_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r   <= '0;
      map_vld_r <= '0;
      a_valid_r <= 1'b0;
      a_mask_r  <= '0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      slots_r   <= slots_nxt;
      map_vld_r <= map_vld_nxt;
      a_valid_r <= a_valid_nxt;
      a_mask_r  <= a_mask_nxt;
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_scan_r    <= a_scan_nxt;
    b_scan_r    <= b_scan_nxt;
    b_press_r   <= b_press_nxt;
    b_last_r    <= b_last_nxt;
    b_inrange_r <= b_inrange_nxt;
    ent_vld_r   <= map_vld_r[raddr];
    c_scan_r    <= c_scan_nxt;
    c_press_r   <= c_press_nxt;
    c_code_r    <= c_code_nxt;
    c_cvalid_r  <= c_cvalid_nxt;
    c_last_r    <= c_last_nxt;
  end

  assign out_req.valid       = c_valid_r;
  assign out_req.scan_code   = c_scan_r;
  assign out_req.is_press    = c_press_r;
  assign out_req.mapped_code = c_code_r;
  assign out_req.code_valid  = c_cvalid_r;
  assign out_req.last        = c_last_r;

endmodule

FILE: hdl/kprt_ram.sv
`timescale 1ns / 1ps

module kprt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 17,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

endmodule

FILE: hdl/kprt_lane.sv
`timescale 1ns / 1ps

module kprt_lane #(
  parameter int REPORT_KEYS = kprt_pkg::REPORT_KEYS_DEF
) (
  input  kprt_pkg::scan_t                                 slot,
  input  logic [REPORT_KEYS-1:0][kprt_pkg::SCAN_W-1:0]   keys,
  output kprt_pkg::lane_stat_t                            stat
);

  import kprt_pkg::*;

  always_comb begin
    stat = '0;
    stat.empty = (slot == '0);
    for (int i = 0; i < REPORT_KEYS; i++) begin
      stat.match[i] = (keys[i] != '0) && (slot == keys[i]);
    end
  end

endmodule

FILE: hdl/kprt_merge.sv
`timescale 1ns / 1ps

module kprt_merge #(
  parameter int REPORT_KEYS = kprt_pkg::REPORT_KEYS_DEF,
  parameter int HELD_SLOTS  = kprt_pkg::HELD_SLOTS_DEF,
  localparam int EV_N = REPORT_KEYS + HELD_SLOTS
) (
  input  logic [REPORT_KEYS-1:0][kprt_pkg::SCAN_W-1:0] keys,
  input  logic [HELD_SLOTS-1:0][kprt_pkg::SCAN_W-1:0]  slots,
  input  kprt_pkg::lane_stat_t [HELD_SLOTS-1:0]         stats,
  output logic [HELD_SLOTS-1:0][kprt_pkg::SCAN_W-1:0]  slots_upd,
  output logic [EV_N-1:0]                               ev_mask,
  output logic [EV_N-1:0][kprt_pkg::SCAN_W-1:0]        ev_scan
);

  import kprt_pkg::*;

  // Presses are resolved in report order; a key stored by an earlier press
  // of the same report counts as held for the later ones.
  always_comb begin
    logic [HELD_SLOTS-1:0]  claimed;
    logic [REPORT_KEYS-1:0] stored;
    logic                   held;
    logic                   found;
    slots_upd = slots;
    claimed   = '0;
    stored    = '0;
    ev_mask   = '0;
    held      = 1'b0;
    found     = 1'b0;
    for (int i = 0; i < REPORT_KEYS; i++) begin
      held = 1'b0;
      for (int j = 0; j < HELD_SLOTS; j++) begin
        if (stats[j].match[i]) begin
          held = 1'b1;
        end
      end
      for (int k = 0; k < i; k++) begin
        if (stored[k] && (keys[k] == keys[i])) begin
          held = 1'b1;
        end
      end
      if ((keys[i] != '0) && !held) begin
        ev_mask[i] = 1'b1;
        found = 1'b0;
        for (int j = 0; j < HELD_SLOTS; j++) begin
          if (!found && stats[j].empty && !claimed[j]) begin
            found        = 1'b1;
            claimed[j]   = 1'b1;
            slots_upd[j] = keys[i];
            stored[i]    = 1'b1;
          end
        end
      end
    end
    for (int j = 0; j < HELD_SLOTS; j++) begin
      if (!stats[j].empty && !(|stats[j].match[REPORT_KEYS-1:0])) begin
        ev_mask[REPORT_KEYS+j] = 1'b1;
        slots_upd[j] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < REPORT_KEYS; i++) begin
      ev_scan[i] = keys[i];
    end
    for (int j = 0; j < HELD_SLOTS; j++) begin
      ev_scan[REPORT_KEYS+j] = slots[j];
    end
  end

endmodule
